// ===== rtl/chsc_pkg.sv =====
// shared constants, types and tables of the horizon scanline cut
`timescale 1ns / 1ps
package chsc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 11;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  // corner offset magnitude needs 17 bits, plus shift and cordic gain growth
  localparam int XW           = 20 + COORD_BITS + 2;
  localparam int ZW           = 32;
  localparam int NW           = XW - 1 + 16;
  localparam int PW           = 50;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [ZW-1:0] HALF_PI_BA = 32'd1073741824;

  localparam logic [2:0] REG_FIELD_LEN  = 3'd0;
  localparam logic [2:0] REG_FIELD_WID  = 3'd1;
  localparam logic [2:0] REG_BORDER     = 3'd2;
  localparam logic [2:0] REG_CAM_HEIGHT = 3'd3;
  localparam logic [2:0] REG_IMAGE_ROWS = 3'd4;
  localparam logic [2:0] REG_TILT_GAIN  = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_VEC1, S_NORM, S_LOAD2, S_VEC2, S_TILT, S_FIN, S_EMIT
  } chsc_state_t;

  typedef struct packed {
    logic              take_pose;
    logic              take_point;
    logic              prep;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              norm;
    logic              load2;
    logic              tilt;
    logic              fin;
    logic              emit;
  } chsc_cmd_t;

  typedef struct packed {
    logic out_free;
  } chsc_stat_t;

  function automatic logic [ZW-1:0] atan_lookup(input logic [4:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933405;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335086;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20860;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2607;
      5'd19: v = 32'd1303;
      5'd20: v = 32'd651;
      5'd21: v = 32'd325;
      5'd22: v = 32'd162;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/chsc_ctrl.sv =====
// sequencer for pose updates and point filtering
`timescale 1ns / 1ps
module chsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_stall,
  input  chsc_pkg::chsc_stat_t stat,
  output chsc_pkg::chsc_cmd_t  cmd
);
  import chsc_pkg::*;

  chsc_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              last_step;

  assign last_step = (cnt_r == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.step  = cnt_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          if (in_mode) begin
            cmd.take_point = 1'b1;
          end else begin
            cmd.take_pose = 1'b1;
            state_nxt     = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_VEC1;
      end
      S_VEC1: begin
        cmd.iter = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.load2 = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_VEC2;
      end
      S_VEC2: begin
        cmd.iter = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (last_step) state_nxt = S_TILT;
      end
      S_TILT: begin
        cmd.tilt  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/chsc_dp.sv =====
// datapath: registers, shared cordic stage, scaling and output item register
`timescale 1ns / 1ps
module chsc_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chsc_pkg::chsc_cmd_t  cmd,
  output chsc_pkg::chsc_stat_t stat,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [15:0]   in_robot_x,
  input  logic signed [15:0]   in_robot_y,
  input  logic signed [15:0]   in_heading,
  input  logic signed [15:0]   in_pan_angle,
  input  logic signed [15:0]   in_tilt_angle,
  input  logic [10:0]          in_point_col,
  input  logic [10:0]          in_point_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [11:0]          out_horizon_out,
  output logic [10:0]          out_col,
  output logic [10:0]          out_row
);
  import chsc_pkg::*;

  logic [14:0] field_len_r, field_wid_r;
  logic [12:0] border_r;
  logic [11:0] cam_height_r, image_rows_r;
  logic [15:0] tilt_gain_r;
  logic [11:0] horizon_r;

  logic signed [15:0] rx_r, ry_r, tilt_r;
  logic               negx_r, negy_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [NW-1:0]        norm_r;
  logic signed [PW-1:0] prod_r;

  logic        ov_r, okind_r;
  logic [11:0] ohor_r;
  logic [10:0] ocol_r, orow_r;

  logic [15:0]          phi;
  logic                 negx, negy;
  logic signed [19:0]   cx, cy, dx, dy;
  logic [16:0]          adx, ady;
  logic signed [XW-1:0] xs, ys;
  logic [ZW-1:0]        atan_v;
  logic [ZW-2:0]        elev;
  logic signed [32:0]   sum;
  logic [PW-1:0]        am;
  logic [PW:0]          am_rnd;
  logic [17:0]          rm, rmc;
  logic [10:0]          half;
  logic [11:0]          hor_new;
  logic                 pass;

  assign stat.out_free = !ov_r || !out_stall;

  // quadrant of heading plus pan; the most negative pattern counts as +pi
  always_comb begin
    phi = in_heading + in_pan_angle;
    if (phi == 16'h8000) begin
      negx = 1'b1;
      negy = 1'b0;
    end else if (!phi[15] && phi != 16'd0) begin
      negx = (phi > 16'd16384);
      negy = 1'b0;
    end else begin
      negy = 1'b1;
      negx = ($signed(phi) <= -16'sd16384);
    end
  end

  always_comb begin
    cx  = $signed({4'd0, {1'b0, field_len_r} + {2'd0, border_r, 1'b0}});
    cy  = $signed({4'd0, {1'b0, field_wid_r} + {2'd0, border_r, 1'b0}});
    dx  = (negx_r ? -cx : cx) - ($signed({{4{rx_r[15]}}, rx_r}) <<< 1);
    dy  = (negy_r ? -cy : cy) - ($signed({{4{ry_r[15]}}, ry_r}) <<< 1);
    adx = dx[19] ? 17'(-dx) : dx[16:0];
    ady = dy[19] ? 17'(-dy) : dy[16:0];
  end

  always_comb begin
    xs     = x_r >>> cmd.step;
    ys     = y_r >>> cmd.step;
    atan_v = atan_lookup(5'(cmd.step));
  end

  // elevation clamp and tilt sum
  always_comb begin
    if (z_r[ZW-1])                elev = '0;
    else if (z_r > $signed(HALF_PI_BA)) elev = HALF_PI_BA[ZW-2:0];
    else                          elev = z_r[ZW-2:0];
    sum = $signed({2'b00, elev}) + ($signed({tilt_r[15], tilt_r, 16'd0}));
  end

  // round half away from zero, clamp to half the image
  always_comb begin
    am      = prod_r[PW-1] ? PW'(-prod_r) : prod_r;
    am_rnd  = {1'b0, am} + (PW+1)'(64'h8000_0000);
    rm      = am_rnd[PW-1:32];
    half    = image_rows_r[11:1];
    rmc     = (rm >= {7'd0, half}) ? {7'd0, half} : rm;
    hor_new = prod_r[PW-1] ? ({1'b0, half} - rmc[11:0]) : ({1'b0, half} + rmc[11:0]);
    pass    = ({1'b0, in_point_row} >= horizon_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_len_r  <= 15'd9000;
      field_wid_r  <= 15'd6000;
      border_r     <= 13'd700;
      cam_height_r <= 12'd500;
      image_rows_r <= 12'd480;
      tilt_gain_r  <= 16'd3840;
      horizon_r    <= '0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_FIELD_LEN:  field_len_r  <= cfg_data[14:0];
          REG_FIELD_WID:  field_wid_r  <= cfg_data[14:0];
          REG_BORDER:     border_r     <= cfg_data[12:0];
          REG_CAM_HEIGHT: cam_height_r <= cfg_data[11:0];
          REG_IMAGE_ROWS: image_rows_r <= cfg_data[11:0];
          REG_TILT_GAIN:  tilt_gain_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.fin) horizon_r <= hor_new;
      if (cmd.emit || (cmd.take_point && pass)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pose) begin
      rx_r   <= in_robot_x;
      ry_r   <= in_robot_y;
      tilt_r <= in_tilt_angle;
      negx_r <= negx;
      negy_r <= negy;
    end
    if (cmd.prep) begin
      x_r <= $signed(XW'(adx) <<< COORD_BITS);
      y_r <= $signed(XW'(ady) <<< COORD_BITS);
      z_r <= '0;
    end else if (cmd.load2) begin
      x_r <= $signed(XW'(((NW+1)'(norm_r) + (NW+1)'(32768)) >> 16));
      y_r <= $signed(XW'({cam_height_r, 1'b0}) <<< COORD_BITS);
      z_r <= '0;
    end else if (cmd.iter) begin
      if (!y_r[XW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + $signed(atan_v);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - $signed(atan_v);
      end
    end
    if (cmd.norm) norm_r <= NW'(x_r[XW-2:0]) * NW'(INV_GAIN_Q16);
    if (cmd.tilt) prod_r <= PW'(sum) * $signed({1'b0, tilt_gain_r});
    if (cmd.emit) begin
      okind_r <= 1'b0;
      ohor_r  <= horizon_r;
      ocol_r  <= '0;
      orow_r  <= '0;
    end else if (cmd.take_point && pass) begin
      okind_r <= 1'b1;
      ohor_r  <= horizon_r;
      ocol_r  <= in_point_col;
      orow_r  <= in_point_row;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_horizon_out = ohor_r;
  assign out_col         = ocol_r;
  assign out_row         = orow_r;

endmodule

// ===== rtl/corner_horizon_scanline_cut_unit.sv =====
// top level of the horizon scanline cut
// point item: result in the output register the next cycle, one per cycle while the output is not stalled
// pose item: the shared cordic stage runs both vectoring passes one iteration per cycle;
// no item taken meanwhile
// reset (synchronous, rst_n low): registers to defaults, horizon row 0, output empty
`timescale 1ns / 1ps
module corner_horizon_scanline_cut_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic signed [15:0] in_heading,
  input  logic signed [15:0] in_pan_angle,
  input  logic signed [15:0] in_tilt_angle,
  input  logic [10:0]        in_point_col,
  input  logic [10:0]        in_point_row,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [11:0]        out_horizon_out,
  output logic [10:0]        out_col,
  output logic [10:0]        out_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import chsc_pkg::*;

  chsc_cmd_t  cmd;
  chsc_stat_t stat;

  assign cfg_ready = 1'b1;

  chsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  chsc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_robot_x      (in_robot_x),
    .in_robot_y      (in_robot_y),
    .in_heading      (in_heading),
    .in_pan_angle    (in_pan_angle),
    .in_tilt_angle   (in_tilt_angle),
    .in_point_col    (in_point_col),
    .in_point_row    (in_point_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_horizon_out (out_horizon_out),
    .out_col         (out_col),
    .out_row         (out_row)
  );

endmodule

// ===== rtl/chsc_checker.sv =====
// port-level checker for the horizon scanline cut, bound to the top level
`timescale 1ns / 1ps
module chsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [11:0] out_horizon_out,
  input logic [10:0] out_col,
  input logic [10:0] out_row
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output item present after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_kind))
    else $error("stalled output item dropped or changed");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_col == 11'd0 && out_row == 11'd0)
    else $error("horizon report carries point data");

  a_point_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> {1'b0, out_row} >= out_horizon_out)
    else $error("point above horizon passed");

  // a pose item keeps the input stalled while the horizon is computed
  a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode |=> in_stall)
    else $error("item taken while a pose is in progress");

endmodule

bind corner_horizon_scanline_cut_unit chsc_checker u_chsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_kind        (out_kind),
  .out_horizon_out (out_horizon_out),
  .out_col         (out_col),
  .out_row         (out_row)
);

// ===== tb/sv/corner_horizon_scanline_cut_checker.sv =====
// checker for the horizon scanline cut: horizon prediction, point filter and result compare
`timescale 1ns / 1ps
module corner_horizon_scanline_cut_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_robot_x,
  input  logic signed [15:0] in_robot_y,
  input  logic signed [15:0] in_heading,
  input  logic signed [15:0] in_pan_angle,
  input  logic signed [15:0] in_tilt_angle,
  input  logic [10:0]        in_point_col,
  input  logic [10:0]        in_point_row,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_kind,
  input  logic [11:0]        out_horizon_out,
  input  logic [10:0]        out_col,
  input  logic [10:0]        out_row,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 horizon_count,
  output int                 passed_count
);
  import chsc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [11:0] horizon;
    logic [10:0] col;
    logic [10:0] row;
  } cut_result_t;

  localparam int STEPS = CORDIC_STEPS;
  localparam int FRAC  = COORD_BITS;

  cut_result_t result_q[$];
  logic [14:0] len_mm, wid_mm;
  logic [12:0] border;
  logic [11:0] cam_h, rows_img, horizon;
  logic [15:0] gain;

  // vectoring rotation toward the x axis; returns angle, mag gets scaled x
  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_lookup(5'(i)));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(atan_lookup(5'(i)));
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic logic [11:0] horizon_from_pose(
    logic signed [15:0] rx, ry, hd, pan, tilt);
    logic signed [15:0] phi16;
    longint phi, cx, cy, dx, dy, mag, corner_dist, elev, sum, prod, mag_p, rows, half;
    phi16 = hd + pan;
    phi = phi16;
    if (phi == -32768) phi = 32768;
    cx = longint'(len_mm) + 2 * longint'(border);
    cy = longint'(wid_mm) + 2 * longint'(border);
    if (phi > 0 && phi <= 16384) begin
    end else if (phi > 16384) begin
      cx = -cx;
    end else if (phi > -16384) begin
      cy = -cy;
    end else begin
      cx = -cx; cy = -cy;
    end
    dx = cx - 2 * longint'(rx);
    dy = cy - 2 * longint'(ry);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    void'(vector_angle(dx <<< FRAC, dy <<< FRAC, mag));
    corner_dist = (mag * 39797 + 32768) >>> 16;
    elev = vector_angle(corner_dist, (2 * longint'(cam_h)) <<< FRAC, mag);
    if (elev < 0) elev = 0;
    if (elev > 64'sd1073741824) elev = 64'sd1073741824;
    sum = elev + longint'(tilt) * 65536;
    prod = sum * longint'(gain);
    mag_p = prod < 0 ? -prod : prod;
    rows = (mag_p + 64'sh80000000) >>> 32;
    if (prod < 0) rows = -rows;
    half = longint'(rows_img) / 2;
    if (rows >= half) rows = half;
    if (rows <= -half) rows = -half;
    return 12'(half + rows);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    cut_result_t r, w;
    if (!rst_n) begin
      len_mm <= 15'd9000; wid_mm <= 15'd6000; border <= 13'd700;
      cam_h <= 12'd500; rows_img <= 12'd480; gain <= 16'd3840;
      horizon <= '0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIELD_LEN:  len_mm   <= cfg_data[14:0];
          REG_FIELD_WID:  wid_mm   <= cfg_data[14:0];
          REG_BORDER:     border   <= cfg_data[12:0];
          REG_CAM_HEIGHT: cam_h    <= cfg_data[11:0];
          REG_IMAGE_ROWS: rows_img <= cfg_data[11:0];
          REG_TILT_GAIN:  gain     <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!in_mode) begin
          r.kind = 1'b0;
          r.horizon = horizon_from_pose(in_robot_x, in_robot_y, in_heading,
                                        in_pan_angle, in_tilt_angle);
          r.col = '0; r.row = '0;
          horizon <= r.horizon;
          result_q.push_back(r);
        end else if ({1'b0, in_point_row} >= horizon) begin
          r.kind = 1'b1; r.horizon = horizon;
          r.col = in_point_col; r.row = in_point_row;
          result_q.push_back(r);
        end
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report("unexpected result, kind", out_kind, -1);
        end else begin
          w = result_q.pop_front();
          if (out_kind) passed_count++; else horizon_count++;
          if (out_kind !== w.kind) report("kind", out_kind, w.kind);
          if (out_horizon_out !== w.horizon) report("horizon", out_horizon_out, w.horizon);
          if (out_col !== w.col) report("column", out_col, w.col);
          if (out_row !== w.row) report("row", out_row, w.row);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    horizon_count = 0;
    passed_count = 0;
  end
endmodule

// ===== tb/sv/corner_horizon_scanline_cut_unit_tb.sv =====
// testbench top of the horizon scanline cut: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module corner_horizon_scanline_cut_unit_tb;
  import chsc_pkg::*;

  localparam int SETTLE = 60;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_mode = 1'b0;
  logic signed [15:0] in_robot_x = '0, in_robot_y = '0, in_heading = '0;
  logic signed [15:0] in_pan_angle = '0, in_tilt_angle = '0;
  logic [10:0] in_point_col = '0, in_point_row = '0;
  logic out_stall = 1'b0, cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_stall, out_valid, out_kind, cfg_ready;
  logic [11:0] out_horizon_out;
  logic [10:0] out_col, out_row;
  int fail_count, pending, horizon_count, passed_count;
  bit calm = 0, hold_req = 0;
  int quiet = 0;

  always #4 clk = ~clk;

  corner_horizon_scanline_cut_unit DUT (.*);

  corner_horizon_scanline_cut_checker chk (.*);

  // receiver: random stalls, a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (300) @(posedge clk);
      hold_req = 0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(logic mode, logic signed [15:0] x, y, hd, pan, tilt,
                           logic [10:0] col, row);
    in_valid <= 1'b1; in_mode <= mode;
    in_robot_x <= x; in_robot_y <= y; in_heading <= hd;
    in_pan_angle <= pan; in_tilt_angle <= tilt;
    in_point_col <= col; in_point_row <= row;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic point_item(logic [10:0] col, row);
    send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), col, row);
  endtask

  task automatic pose_item(logic signed [15:0] x, y, hd, pan, tilt);
    send_item(1'b0, x, y, hd, pan, tilt, 11'($urandom), 11'($urandom));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setup(logic [15:0] len, wid, brd, cam, rows, gain);
    drain();
    write_reg(REG_FIELD_LEN, len);
    write_reg(REG_FIELD_WID, wid);
    write_reg(REG_BORDER, brd);
    write_reg(REG_CAM_HEIGHT, cam);
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_TILT_GAIN, gain);
  endtask

  // mostly points, a pose now and then, poses mostly on the field
  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(3) == 0)
          pose_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom));
        else
          pose_item(16'($urandom_range(12000)) - 16'sd6000,
                    16'($urandom_range(8000)) - 16'sd4000,
                    16'($urandom), 16'($urandom),
                    16'($urandom_range(8000)) - 16'sd4000);
      end else begin
        point_item(11'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // points before any pose all pass, then quadrant edges and extremes
    point_item(11'd0, 11'd0);
    point_item(11'd2047, 11'd2047);
    pose_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    pose_item(16'sd1000, -16'sd500, 16'sd16384, 16'sd0, 16'sd0);
    pose_item(16'sd0, 16'sd0, 16'sd16384, 16'sd1, 16'sd100);
    pose_item(16'sd0, 16'sd0, -16'sd32768, 16'sd0, -16'sd100);
    pose_item(16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0);
    pose_item(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0);
    pose_item(16'sd0, 16'sd0, -16'sd16383, 16'sd0, 16'sd0);
    pose_item(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    pose_item(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    pose_item(16'sd5200, 16'sd3700, 16'sd4000, 16'sd0, 16'sd0);
    point_item(11'd5, 11'd239);
    point_item(11'd6, 11'd240);
    point_item(11'd7, 11'd241);
    pose_item(16'sd0, 16'sd0, 16'sd3000, 16'sd0, -16'sd2000);
    point_item(11'd2047, 11'd0);
    point_item(11'd0, 11'd2047);

    random_burst(130);

    // long receiver hold-off while points keep coming
    drain();
    calm = 1;
    hold_req = 1;
    for (int i = 0; i < 40; i++) point_item(11'($urandom), 11'($urandom));
    calm = 0;

    write_setup(16'd32767, 16'd32767, 16'd8191, 16'd4095, 16'd2048, 16'd65535);
    random_burst(140);
    write_setup(16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd0);
    random_burst(120);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    write_setup(16'hFFFF, 16'd100, 16'hFFFF, 16'd0, 16'd1, 16'd60000);
    random_burst(100);

    // stretch with no idling at all
    write_setup(16'd9000, 16'd6000, 16'd700, 16'd300, 16'd480, 16'd3840);
    calm = 1;
    random_burst(150);
    calm = 0;

    write_setup(16'($urandom_range(32767)), 16'($urandom_range(32767)),
                16'($urandom_range(8191)), 16'($urandom_range(1, 4095)),
                16'($urandom_range(2, 2048)), 16'($urandom));
    random_burst(150);

    drain();
    $display("run covered %0d horizon reports and %0d passed points over six settings",
             horizon_count, passed_count);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/chsc_pkg.sv
rtl/chsc_ctrl.sv
rtl/chsc_dp.sv
rtl/corner_horizon_scanline_cut_unit.sv
rtl/chsc_checker.sv
tb/sv/corner_horizon_scanline_cut_checker.sv
tb/sv/corner_horizon_scanline_cut_unit_tb.sv
